@@ design/udp_ipv4_ethernet_frame_builder_defines.svh @@
// ----------------------------------------------------------------------------
// Frame builder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UDP_IPV4_ETHERNET_FRAME_BUILDER_DEFINES_SVH
`define UDP_IPV4_ETHERNET_FRAME_BUILDER_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define UDPFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next.
`define UDPFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/udpfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame builder package
// Payload types, header constants and header byte selection.
// ----------------------------------------------------------------------------
package udpfb_pkg;

	localparam int HDR_LEN     = 42;
	localparam int IP_HDR_LEN  = 20;
	localparam int UDP_HDR_LEN = 8;
	localparam int ETH_HDR_LEN = 14;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int HIDX_W      = $clog2(HDR_LEN + 1);
	localparam int SUM_W       = 19;

	localparam logic [10:0] MAX_BODY     = 11'd1472;
	localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
	localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
	localparam logic [7:0]  IP_VER_IHL   = 8'h45;
	localparam logic [7:0]  IP_TTL       = 8'd128;
	localparam logic [7:0]  IP_PROTO_UDP = 8'd17;

	typedef enum logic [2:0] {
		CFG_SOURCE_MAC  = 3'd0,
		CFG_DEST_MAC    = 3'd1,
		CFG_SOURCE_IP   = 3'd2,
		CFG_DEST_IP     = 3'd3,
		CFG_SOURCE_PORT = 3'd4,
		CFG_DEST_PORT   = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [10:0] body_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       run_last;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [47:0] source_mac;
		logic [47:0] dest_mac;
		logic [31:0] source_ip;
		logic [31:0] dest_ip;
		logic [15:0] source_port;
		logic [15:0] dest_port;
	} cfg_regs_t;

	// One classified input item waiting for the back end.
	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [10:0] body_length;
		logic        start;
		logic        empty;
		logic        last;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [15:0] ip_total_len(input logic [10:0] len);
		return 16'(IP_HDR_LEN + UDP_HDR_LEN) + {5'd0, len};
	endfunction

	function automatic logic [15:0] udp_total_len(input logic [10:0] len);
		return 16'(UDP_HDR_LEN) + {5'd0, len};
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [HIDX_W-1:0] idx, input cfg_regs_t c,
			input logic [10:0] len, input logic [15:0] csum);
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [7:0]  b;
		ip_len  = ip_total_len(len);
		udp_len = udp_total_len(len);
		case (idx)
			6'd0:  b = c.dest_mac[47:40];
			6'd1:  b = c.dest_mac[39:32];
			6'd2:  b = c.dest_mac[31:24];
			6'd3:  b = c.dest_mac[23:16];
			6'd4:  b = c.dest_mac[15:8];
			6'd5:  b = c.dest_mac[7:0];
			6'd6:  b = c.source_mac[47:40];
			6'd7:  b = c.source_mac[39:32];
			6'd8:  b = c.source_mac[31:24];
			6'd9:  b = c.source_mac[23:16];
			6'd10: b = c.source_mac[15:8];
			6'd11: b = c.source_mac[7:0];
			6'd12: b = ETHERTYPE_HI;
			6'd13: b = ETHERTYPE_LO;
			6'd14: b = IP_VER_IHL;
			6'd16: b = ip_len[15:8];
			6'd17: b = ip_len[7:0];
			6'd22: b = IP_TTL;
			6'd23: b = IP_PROTO_UDP;
			6'd24: b = csum[15:8];
			6'd25: b = csum[7:0];
			6'd26: b = c.source_ip[31:24];
			6'd27: b = c.source_ip[23:16];
			6'd28: b = c.source_ip[15:8];
			6'd29: b = c.source_ip[7:0];
			6'd30: b = c.dest_ip[31:24];
			6'd31: b = c.dest_ip[23:16];
			6'd32: b = c.dest_ip[15:8];
			6'd33: b = c.dest_ip[7:0];
			6'd34: b = c.source_port[15:8];
			6'd35: b = c.source_port[7:0];
			6'd36: b = c.dest_port[15:8];
			6'd37: b = c.dest_port[7:0];
			6'd38: b = udp_len[15:8];
			6'd39: b = udp_len[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ design/udpfb_cfg.sv @@
// ----------------------------------------------------------------------------
// Frame builder configuration registers
// Address register file plus the fixed part of the IPv4 header checksum.
// ----------------------------------------------------------------------------
module udpfb_cfg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [47:0]           wr_data,
	output udpfb_pkg::cfg_regs_t  regs,
	output logic [18:0]           base_sum
);
	import udpfb_pkg::*;

	cfg_regs_t         regs_q;
	logic [SUM_W-1:0]  base_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.source_mac  <= 48'h0202846A9601;
			regs_q.dest_mac    <= 48'hFFFFFFFFFFFF;
			regs_q.source_ip   <= 32'hA9FE0001;
			regs_q.dest_ip     <= 32'hA9FEFFFF;
			regs_q.source_port <= 16'd25565;
			regs_q.dest_port   <= 16'd25565;
		end else if (wr_en) begin
			case (cfg_index_t'(wr_index))
				CFG_SOURCE_MAC:  regs_q.source_mac  <= wr_data;
				CFG_DEST_MAC:    regs_q.dest_mac    <= wr_data;
				CFG_SOURCE_IP:   regs_q.source_ip   <= wr_data[31:0];
				CFG_DEST_IP:     regs_q.dest_ip     <= wr_data[31:0];
				CFG_SOURCE_PORT: regs_q.source_port <= wr_data[15:0];
				CFG_DEST_PORT:   regs_q.dest_port   <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Sum of every header word that does not depend on the body length.
	always_ff @(posedge clk) begin
		base_sum_q <= {3'd0, IP_VER_IHL, 8'h00} + {3'd0, IP_TTL, IP_PROTO_UDP}
			+ {3'd0, regs_q.source_ip[31:16]} + {3'd0, regs_q.source_ip[15:0]}
			+ {3'd0, regs_q.dest_ip[31:16]} + {3'd0, regs_q.dest_ip[15:0]};
	end

	assign regs     = regs_q;
	assign base_sum = base_sum_q;

endmodule

@@ design/udpfb_front.sv @@
// ----------------------------------------------------------------------------
// Frame builder front end
// Track message position and tag each payload byte for the back end.
// ----------------------------------------------------------------------------
`include "udp_ipv4_ethernet_frame_builder_defines.svh"

module udpfb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  udpfb_pkg::in_item_t  item,
	output udpfb_pkg::entry_t    entry
);
	import udpfb_pkg::*;

	logic        in_message_q;
	logic [10:0] remaining_q;
	logic        in_message_d;
	logic [10:0] remaining_d;
	logic [10:0] len_sat;

	always_comb begin
		len_sat = (item.body_length > MAX_BODY) ? MAX_BODY : item.body_length;
		entry.payload_byte = item.payload_byte;
		entry.body_length  = len_sat;
		entry.start        = !in_message_q;
		entry.empty        = 1'b0;
		entry.last         = 1'b0;
		if (!in_message_q) begin
			entry.empty  = (len_sat == 11'd0);
			remaining_d  = (len_sat == 11'd0) ? 11'd0 : len_sat - 11'd1;
		end else begin
			remaining_d  = remaining_q - 11'd1;
		end
		entry.last   = (remaining_d == 11'd0);
		in_message_d = (remaining_d != 11'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_message_q <= 1'b0;
			remaining_q  <= 11'd0;
		end else if (accept) begin
			in_message_q <= in_message_d;
			remaining_q  <= remaining_d;
		end
	end

	`UDPFB_ASSERT(a_msg_has_bytes, !in_message_q || remaining_q != 11'd0, "message without bytes")
	`UDPFB_ASSERT_NEXT(a_msg_ends, accept && in_message_q && remaining_q == 11'd1, !in_message_q, "message did not end")

endmodule

@@ design/udpfb_queue.sv @@
// ----------------------------------------------------------------------------
// Frame builder entry queue
// Short FIFO that decouples the front end from header emission.
// ----------------------------------------------------------------------------
module udpfb_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  udpfb_pkg::entry_t          push_data,
	input  logic                       pop,
	output udpfb_pkg::entry_t          head,
	output udpfb_pkg::queue_status_t   status
);
	import udpfb_pkg::*;

	entry_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head         = slot_q[rd_ptr_q];
	assign status.full  = (count_q == (QPTR_W+1)'(QDEPTH));
	assign status.empty = (count_q == '0);

endmodule

@@ design/udpfb_back.sv @@
// ----------------------------------------------------------------------------
// Frame builder back end
// Emit the header at each message start, then the payload byte of each non-empty entry.
// ----------------------------------------------------------------------------
`include "udp_ipv4_ethernet_frame_builder_defines.svh"

module udpfb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  udpfb_pkg::cfg_regs_t      regs,
	input  logic [18:0]               base_sum,
	input  udpfb_pkg::entry_t         head,
	input  udpfb_pkg::queue_status_t  status,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output udpfb_pkg::out_item_t      out_data
);
	import udpfb_pkg::*;

	logic [HIDX_W-1:0] hdr_idx_q;
	logic [HIDX_W-1:0] hdr_idx_d;
	logic [15:0]       csum_q;
	logic              out_valid_q;
	out_item_t         out_q;
	out_item_t         res;
	logic              load;
	logic [SUM_W-1:0]  sum;
	logic [16:0]       fold1;
	logic [15:0]       fold2;

	// Checksum of the head entry; stable long before byte 24 goes out.
	always_comb begin
		sum   = base_sum + {3'd0, ip_total_len(head.body_length)};
		fold1 = {1'b0, sum[15:0]} + {14'd0, sum[SUM_W-1:16]};
		fold2 = fold1[15:0] + {15'd0, fold1[16]};
	end

	always_ff @(posedge clk) begin
		csum_q <= ~fold2;
	end

	always_comb begin
		load      = !out_valid_q || !out_stall;
		pop       = 1'b0;
		hdr_idx_d = hdr_idx_q;
		res.frame_byte = head.payload_byte;
		res.run_last   = 1'b1;
		res.frame_last = head.last;
		if (head.start && hdr_idx_q != HIDX_W'(HDR_LEN)) begin
			res.frame_byte = hdr_byte(hdr_idx_q, regs, head.body_length, csum_q);
			res.run_last   = 1'b0;
			res.frame_last = 1'b0;
			hdr_idx_d      = hdr_idx_q + 1'b1;
			if (hdr_idx_q == HIDX_W'(HDR_LEN - 1) && head.empty) begin
				res.run_last   = 1'b1;
				res.frame_last = 1'b1;
				pop            = load && !status.empty;
				hdr_idx_d      = '0;
			end
		end else begin
			pop       = load && !status.empty;
			hdr_idx_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hdr_idx_q   <= '0;
		end else if (load) begin
			out_valid_q <= !status.empty;
			if (!status.empty) begin
				hdr_idx_q <= hdr_idx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !status.empty) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`UDPFB_ASSERT(a_frame_last_ends_run, !out_valid_q || !out_q.frame_last || out_q.run_last, "frame_last without run_last")
	`UDPFB_ASSERT(a_header_has_head, hdr_idx_q == '0 || !status.empty, "header in progress with empty queue")

endmodule

@@ design/udp_ipv4_ethernet_frame_builder.sv @@
// ----------------------------------------------------------------------------
// UDP/IPv4/Ethernet frame builder
// Wrap a stream of UDP body bytes into Ethernet frames without FCS.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one UDP body byte per transfer, tagged with the whole body length.
//            The length is taken on the first byte of a message only, and
//            saturates at the maximum body size.
//   out_*  : one frame byte per transfer. run_last marks the last byte caused
//            by an input transfer, frame_last the last byte of a frame.
//   cfg_*  : register writes (MACs, IPs, ports); cfg_ready is always high.
//            Write only while no frame is in flight.
// Order: with the queue empty, an accepted first body byte is written into the
//   queue, and from there its first header byte is loaded into the output
//   register; the 42 header bytes follow one per cycle while out_stall is
//   low, then that body byte. Later body bytes follow as they reach the head
//   of the queue.
// Throughput: the output register moves one byte per cycle while out_stall is
//   low; the back end's byte sequencer sets the rate. A four-entry queue lets
//   input bytes keep arriving during the header, and in_stall rises when it
//   fills.
// Reset: registers return to their defaults, queue and message state clear.
// When the receiver stalls, the output byte holds and the queue fills.
// ----------------------------------------------------------------------------
module udp_ipv4_ethernet_frame_builder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  udpfb_pkg::in_item_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output udpfb_pkg::out_item_t  out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [47:0]           cfg_data
);
	import udpfb_pkg::*;

	cfg_regs_t      regs;
	logic [18:0]    base_sum;
	entry_t         entry;
	entry_t         head;
	queue_status_t  status;
	logic           accept;
	logic           pop;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	udpfb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.regs     (regs),
		.base_sum (base_sum)
	);

	// Hold input off only when the queue has no room.
	assign in_stall = status.full;
	assign accept   = in_valid && !in_stall;

	udpfb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_data),
		.entry  (entry)
	);

	udpfb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.status    (status)
	);

	// Advance through header and payload bytes as the output drains.
	udpfb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.base_sum  (base_sum),
		.head      (head),
		.status    (status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ tb/udp_ipv4_ethernet_frame_builder_checker.sv @@
// ----------------------------------------------------------------------------
// Frame builder checker
// Watches the input, output and register channels of the frame builder,
// predicts every frame byte and compares the output stream against it.
// ----------------------------------------------------------------------------
module udpfb_frame_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  udpfb_pkg::in_item_t   in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  udpfb_pkg::out_item_t  out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [47:0]           cfg_data,
	output int                    fail_count,
	output int                    backlog
);
	timeunit 1ns;
	timeprecision 1ps;

	import udpfb_pkg::*;

	localparam logic [47:0] RST_SOURCE_MAC  = 48'h0202_846A_9601;
	localparam logic [47:0] RST_DEST_MAC    = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] RST_SOURCE_IP   = 32'hA9FE_0001;
	localparam logic [31:0] RST_DEST_IP     = 32'hA9FE_FFFF;
	localparam logic [15:0] RST_PORT        = 16'd25565;

	cfg_regs_t   regs;
	logic        in_msg;
	logic [10:0] body_left;
	out_item_t   frame_bytes_due[$];
	out_item_t   want;

	function automatic logic [15:0] ip_checksum(input logic [15:0] total_len);
		logic [19:0] acc;
		acc = 20'h04500 + {4'd0, total_len} + 20'h08011
			+ {4'd0, regs.source_ip[31:16]} + {4'd0, regs.source_ip[15:0]}
			+ {4'd0, regs.dest_ip[31:16]} + {4'd0, regs.dest_ip[15:0]};
		// end-around carry, twice covers any carry out of the first fold
		acc = {4'd0, acc[15:0]} + {16'd0, acc[19:16]};
		acc = {4'd0, acc[15:0]} + {16'd0, acc[19:16]};
		return ~acc[15:0];
	endfunction

	function automatic void push_byte(input logic [7:0] b, input logic rl, input logic fl);
		out_item_t r;
		r.frame_byte = b;
		r.run_last   = rl;
		r.frame_last = fl;
		frame_bytes_due.push_back(r);
	endfunction

	// Expected frame bytes caused by one accepted body byte.
	function automatic void predict_frame_bytes(input in_item_t it);
		logic [10:0] len;
		logic [15:0] ip_len;
		logic [15:0] udp_len;
		logic [15:0] csum;
		logic [7:0]  hdr [0:41];
		int          i;
		if (!in_msg) begin
			len     = (it.body_length > MAX_BODY) ? MAX_BODY : it.body_length;
			ip_len  = 16'd28 + {5'd0, len};
			udp_len = 16'd8 + {5'd0, len};
			csum    = ip_checksum(ip_len);
			for (i = 0; i < 6; i++) begin
				hdr[i]     = regs.dest_mac[47 - 8 * i -: 8];
				hdr[6 + i] = regs.source_mac[47 - 8 * i -: 8];
			end
			hdr[12] = 8'h08;
			hdr[13] = 8'h00;
			hdr[14] = 8'h45;
			hdr[15] = 8'h00;
			hdr[16] = ip_len[15:8];
			hdr[17] = ip_len[7:0];
			for (i = 18; i < 22; i++)
				hdr[i] = 8'h00;
			hdr[22] = 8'd128;
			hdr[23] = 8'd17;
			hdr[24] = csum[15:8];
			hdr[25] = csum[7:0];
			for (i = 0; i < 4; i++) begin
				hdr[26 + i] = regs.source_ip[31 - 8 * i -: 8];
				hdr[30 + i] = regs.dest_ip[31 - 8 * i -: 8];
			end
			hdr[34] = regs.source_port[15:8];
			hdr[35] = regs.source_port[7:0];
			hdr[36] = regs.dest_port[15:8];
			hdr[37] = regs.dest_port[7:0];
			hdr[38] = udp_len[15:8];
			hdr[39] = udp_len[7:0];
			hdr[40] = 8'h00;
			hdr[41] = 8'h00;
			for (i = 0; i < 41; i++)
				push_byte(hdr[i], 1'b0, 1'b0);
			if (len == 11'd0) begin
				// empty body: the header alone closes the frame
				push_byte(hdr[41], 1'b1, 1'b1);
				return;
			end
			push_byte(hdr[41], 1'b0, 1'b0);
			body_left = len;
			in_msg    = 1'b1;
		end
		if (body_left != 11'd0)
			body_left--;
		if (body_left == 11'd0) begin
			in_msg = 1'b0;
			push_byte(it.payload_byte, 1'b1, 1'b1);
		end else begin
			push_byte(it.payload_byte, 1'b1, 1'b0);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.source_mac  = RST_SOURCE_MAC;
			regs.dest_mac    = RST_DEST_MAC;
			regs.source_ip   = RST_SOURCE_IP;
			regs.dest_ip     = RST_DEST_IP;
			regs.source_port = RST_PORT;
			regs.dest_port   = RST_PORT;
			in_msg           = 1'b0;
			body_left        = '0;
			frame_bytes_due.delete();
			fail_count       = 0;
			backlog          = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SOURCE_MAC:  regs.source_mac  = cfg_data;
					CFG_DEST_MAC:    regs.dest_mac    = cfg_data;
					CFG_SOURCE_IP:   regs.source_ip   = cfg_data[31:0];
					CFG_DEST_IP:     regs.dest_ip     = cfg_data[31:0];
					CFG_SOURCE_PORT: regs.source_port = cfg_data[15:0];
					CFG_DEST_PORT:   regs.dest_port   = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_frame_bytes(in_data);
			if (out_valid && !out_stall) begin
				if (frame_bytes_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected frame byte, expected none, %s %h %b %b",
						$time, "actual byte/run_last/frame_last",
						out_data.frame_byte, out_data.run_last, out_data.frame_last);
				end else begin
					want = frame_bytes_due.pop_front();
					if (out_data !== want) begin
						fail_count++;
						$display("%0t: frame byte mismatch, expected %h %b %b, actual %h %b %b",
							$time, want.frame_byte, want.run_last, want.frame_last,
							out_data.frame_byte, out_data.run_last, out_data.frame_last);
					end
				end
			end
			backlog = frame_bytes_due.size();
		end
	end

endmodule

@@ tb/tb_udp_ipv4_ethernet_frame_builder.sv @@
// ----------------------------------------------------------------------------
// Frame builder testbench
// Drives UDP body messages and register settings into the frame builder,
// with random idling on both channels; a checker beside the block predicts
// and compares every frame byte.
// ----------------------------------------------------------------------------
module tb_udp_ipv4_ethernet_frame_builder;
	timeunit 1ns;
	timeprecision 1ps;

	import udpfb_pkg::*;

	localparam int          CYCLE_LIMIT   = 1_000_000;
	localparam int          RANDOM_ITEMS  = 280;
	localparam int          PHASE_ITEMS   = 40;
	localparam int          TAIL_ITEMS    = 8;
	localparam int          IDLE_PERCENT  = 21;
	localparam logic [2:0]  CFG_UNUSED_LO = 3'd6;
	localparam logic [2:0]  CFG_UNUSED_HI = 3'd7;
	localparam logic [47:0] ALL_ONES      = 48'hFFFF_FFFF_FFFF;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [47:0] cfg_data  = '0;

	int fail_count;
	int backlog;
	int cycle_count = 0;
	int items_sent  = 0;
	bit calm        = 1'b0;   // no idling on either side while set

	udp_ipv4_ethernet_frame_builder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	udpfb_frame_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	always #10 clk = ~clk;

	// Hard stop: far beyond the slowest legal run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: stall at random, never during the calm stretch.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);

	// Send one body byte. Idle at random first, then hold the transfer until
	// the block takes it; stall is sampled at the falling edge so it is
	// settled for the coming rising edge.
	task automatic send_item(input in_item_t it);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// Send a whole message: the first byte carries the body length, later
	// bytes carry random lengths that the block must ignore. A zero length
	// still needs one transfer to start the header.
	task automatic send_message(input logic [10:0] len, input logic [7:0] first_byte);
		int       count;
		int       k;
		in_item_t it;
		count = (len == 0) ? 1 : ((len > MAX_BODY) ? int'(MAX_BODY) : int'(len));
		for (k = 0; k < count; k++) begin
			it.payload_byte = (k == 0) ? first_byte : 8'($urandom);
			it.body_length  = (k == 0) ? len : 11'($urandom);
			send_item(it);
		end
	endtask

	// One register write; cfg_valid stays high until the caller drops it.
	task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Write all six registers with one value, then drop the channel.
	task automatic write_all_regs(input logic [47:0] value);
		write_reg(CFG_SOURCE_MAC, value);
		write_reg(CFG_DEST_MAC, value);
		write_reg(CFG_SOURCE_IP, value);
		write_reg(CFG_DEST_IP, value);
		write_reg(CFG_SOURCE_PORT, value);
		write_reg(CFG_DEST_PORT, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a register value: mostly random, sometimes an extreme.
	function automatic logic [47:0] reg_value();
		int r;
		r = $urandom_range(7);
		if (r == 0)
			return '0;
		if (r == 1)
			return ALL_ONES;
		return {16'($urandom), 32'($urandom)};
	endfunction

	task automatic shuffle_regs();
		write_reg(CFG_SOURCE_MAC, reg_value());
		write_reg(CFG_DEST_MAC, reg_value());
		write_reg(CFG_SOURCE_IP, reg_value());
		write_reg(CFG_DEST_IP, reg_value());
		write_reg(CFG_SOURCE_PORT, reg_value());
		write_reg(CFG_DEST_PORT, reg_value());
		// now and then poke an unmapped index; it must change nothing
		if ($urandom_range(3) == 0)
			write_reg($urandom_range(1) ? CFG_UNUSED_HI : CFG_UNUSED_LO, reg_value());
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly short bodies, some empty, a few longer ones.
	function automatic logic [10:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return 11'd0;
		if (r < 85)
			return 11'($urandom_range(1, 12));
		if (r < 97)
			return 11'($urandom_range(13, 64));
		return 11'($urandom_range(65, 200));
	endfunction

	// Drop valid, wait until every predicted byte has come out, then let the
	// block settle so it is idle before any register write.
	task automatic drain_frames();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (backlog != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int       phase;
		int       phase_start;
		int       k;
		in_item_t it;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed, reset register values: empty body with an ignored
		// payload, single-byte bodies at both byte extremes, and two longer
		// bodies whose later bytes carry lengths that must be ignored.
		send_message(11'd0, 8'hFF);
		send_message(11'd1, 8'h00);
		send_message(11'd1, 8'hFF);
		send_message(11'd4, 8'h5A);
		send_message(11'd2, 8'hA5);
		drain_frames();

		// All registers at their maximum.
		write_all_regs(ALL_ONES);
		send_message(11'd0, 8'h00);
		send_message(11'd3, 8'hFF);
		drain_frames();

		// All registers cleared.
		write_all_regs('0);
		send_message(11'd0, 8'h3C);
		send_message(11'd2, 8'hC3);
		drain_frames();

		// Unmapped indexes with random data: headers stay as they were.
		write_reg(CFG_UNUSED_LO, ALL_ONES);
		write_reg(CFG_UNUSED_HI, {16'($urandom), 32'($urandom)});
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_message(11'd1, 8'h81);
		drain_frames();

		// Random phases: fresh registers, then a run of random messages.
		phase       = 0;
		phase_start = items_sent;
		while (items_sent - phase_start < RANDOM_ITEMS) begin
			shuffle_regs();
			calm <= (phase == 2);
			begin
				int base;
				base = items_sent;
				while (items_sent - base < PHASE_ITEMS)
					send_message(pick_length(), 8'($urandom));
			end
			drain_frames();
			calm <= 1'b0;
			phase++;
		end

		// Top of the length field on a last message that stays open: its
		// header carries the length saturated to the largest body.
		shuffle_regs();
		for (k = 0; k < TAIL_ITEMS; k++) begin
			it.payload_byte = 8'($urandom);
			it.body_length  = (k == 0) ? 11'h7FF : 11'($urandom);
			send_item(it);
		end
		drain_frames();

		// Let any stray byte show up before the verdict.
		repeat (60) @(posedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/udpfb_pkg.sv
design/udpfb_cfg.sv
design/udpfb_front.sv
design/udpfb_queue.sv
design/udpfb_back.sv
design/udp_ipv4_ethernet_frame_builder.sv
tb/udp_ipv4_ethernet_frame_builder_checker.sv
tb/tb_udp_ipv4_ethernet_frame_builder.sv
